FILE: rtl/pcu_pkg.sv
// Package for the pixel composite unit: transaction payload structs,
// configuration struct, mode codes and register indexes. No dependencies.
package pcu_pkg;

   localparam int unsigned CHAN_W = 8;
   localparam int unsigned MODE_W = 2;
   localparam int unsigned CSR_INDEX_W = 2;

   localparam logic [MODE_W-1:0] MODE_COPY  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_BLEND = 2'd1;
   localparam logic [MODE_W-1:0] MODE_KEY   = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_BLEND_MODE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_BLUE   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_GREEN  = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_RED    = 2'd3;

   typedef struct packed {
      logic [CHAN_W-1:0] src_blue;
      logic [CHAN_W-1:0] src_green;
      logic [CHAN_W-1:0] src_red;
      logic [CHAN_W-1:0] src_alpha;
      logic [CHAN_W-1:0] dst_blue;
      logic [CHAN_W-1:0] dst_green;
      logic [CHAN_W-1:0] dst_red;
   } pcu_req_type;

   typedef struct packed {
      logic [CHAN_W-1:0] out_blue;
      logic [CHAN_W-1:0] out_green;
      logic [CHAN_W-1:0] out_red;
      logic              dst_kept;
   } pcu_rsp_type;

   typedef struct packed {
      logic [MODE_W-1:0] blend_mode;
      logic [CHAN_W-1:0] key_blue;
      logic [CHAN_W-1:0] key_green;
      logic [CHAN_W-1:0] key_red;
   } pcu_cfg_type;

endpackage

FILE: rtl/pixel_composite_unit_core.sv
// Pixel composite unit top level: input register, compositing logic,
// result register and configuration registers. Depends on pcu_pkg and pcu_composite.
//
// Accepts one pixel transaction per clock cycle while req_ready is high and
// returns one result per pixel. Each pixel is held in the input register,
// then in the result register, with the blend multiply and divide-by-255
// done between them. The block holds up to two transactions: a waiting
// result stops new pixels only once the input register also holds a pixel,
// and req_ready then follows rsp_ready in the same cycle. Configuration
// writes are always accepted, as csr_ready is tied high.
module pixel_composite_unit_core
   import pcu_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  pcu_req_type            req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output pcu_rsp_type            rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CHAN_W-1:0]      csr_wdata
);

   pcu_cfg_type cfg_ff, cfg_in;
   logic        pix_valid_ff, pix_valid_in;
   pcu_req_type pix_ff, pix_in;
   logic        res_valid_ff, res_valid_in;
   pcu_rsp_type res_ff, res_in;
   pcu_rsp_type comp_res;
   logic        res_load;
   logic        pix_load;

   pcu_composite u_composite (
      .cfg (cfg_ff),
      .pix (pix_ff),
      .res (comp_res)
   );

   assign res_load  = !res_valid_ff || rsp_ready;
   assign req_ready = !pix_valid_ff || res_load;
   assign pix_load  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_BLEND_MODE: cfg_in.blend_mode = csr_wdata[MODE_W-1:0];
            CSR_KEY_BLUE:   cfg_in.key_blue   = csr_wdata;
            CSR_KEY_GREEN:  cfg_in.key_green  = csr_wdata;
            CSR_KEY_RED:    cfg_in.key_red    = csr_wdata;
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      pix_valid_in = pix_valid_ff;
      pix_in       = pix_ff;
      res_valid_in = res_valid_ff;
      res_in       = res_ff;
      if (res_load) begin
         res_valid_in = pix_valid_ff;
         res_in       = comp_res;
         pix_valid_in = 1'b0;
      end
      if (pix_load) begin
         pix_valid_in = 1'b1;
         pix_in       = req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= '0;
         pix_valid_ff <= 1'b0;
         res_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         pix_valid_ff <= pix_valid_in;
         res_valid_ff <= res_valid_in;
      end
      pix_ff <= pix_in;
      res_ff <= res_in;
   end

   assign rsp_valid = res_valid_ff;
   assign rsp_data  = res_ff;

   a_stall_holds_pixel: assert property (@(posedge clock) disable iff (reset)
      pix_valid_ff && !res_load |=> pix_valid_ff && $stable(pix_ff))
      else $error("input stage lost or changed a stalled pixel");

   a_kept_only_in_key_mode: assert property (@(posedge clock) disable iff (reset)
      res_valid_ff && res_ff.dst_kept |-> cfg_ff.blend_mode == MODE_KEY)
      else $error("dst_kept set outside color key mode");

   a_reset_empties: assert property (@(posedge clock)
      reset |=> !pix_valid_ff && !res_valid_ff)
      else $error("pipeline not empty after reset");

endmodule

FILE: rtl/pcu_mix_channel.sv
// One channel of the alpha blend: (a*s + (255-a)*d) / 255, truncated.
// Depends on pcu_pkg.
module pcu_mix_channel
   import pcu_pkg::*;
(
   input  logic [CHAN_W-1:0] src,
   input  logic [CHAN_W-1:0] dst,
   input  logic [CHAN_W-1:0] alpha,
   output logic [CHAN_W-1:0] mix
);

   logic signed [CHAN_W:0]     diff;
   logic signed [CHAN_W:0]     alpha_s;
   logic signed [2*CHAN_W+1:0] prod;
   logic signed [2*CHAN_W+1:0] base;
   logic signed [2*CHAN_W+1:0] sum;
   logic [2*CHAN_W-1:0]        num;
   logic [2*CHAN_W:0]          quo;

   // a*s + (255-a)*d == 255*d + a*(s-d), one multiply per channel
   always_comb begin
      diff    = $signed({1'b0, src}) - $signed({1'b0, dst});
      alpha_s = $signed({1'b0, alpha});
      prod    = (2*CHAN_W+2)'(alpha_s * diff);
      base    = $signed({2'b00, dst, {CHAN_W{1'b0}}}) - $signed({{(CHAN_W+2){1'b0}}, dst});
      sum     = base + prod;
      num     = sum[2*CHAN_W-1:0];
      // exact x/255 for x < 65535: (x + 1 + (x >> 8)) >> 8
      quo     = {1'b0, num} + (2*CHAN_W+1)'(1)
                + {{(CHAN_W+1){1'b0}}, num[2*CHAN_W-1:CHAN_W]};
      mix     = quo[2*CHAN_W-1:CHAN_W];
   end

endmodule

FILE: rtl/pcu_composite.sv
// Per-pixel compositing logic: copy, alpha blend or color key select; the unused mode passes dst.
// Depends on pcu_pkg and pcu_mix_channel.
module pcu_composite
   import pcu_pkg::*;
(
   input  pcu_cfg_type cfg,
   input  pcu_req_type pix,
   output pcu_rsp_type res
);

   logic [CHAN_W-1:0] mix_blue;
   logic [CHAN_W-1:0] mix_green;
   logic [CHAN_W-1:0] mix_red;
   logic              key_hit;

   pcu_mix_channel u_mix_blue (
      .src   (pix.src_blue),
      .dst   (pix.dst_blue),
      .alpha (pix.src_alpha),
      .mix   (mix_blue)
   );

   pcu_mix_channel u_mix_green (
      .src   (pix.src_green),
      .dst   (pix.dst_green),
      .alpha (pix.src_alpha),
      .mix   (mix_green)
   );

   pcu_mix_channel u_mix_red (
      .src   (pix.src_red),
      .dst   (pix.dst_red),
      .alpha (pix.src_alpha),
      .mix   (mix_red)
   );

   assign key_hit = (pix.src_blue == cfg.key_blue) && (pix.src_green == cfg.key_green)
                    && (pix.src_red == cfg.key_red);

   always_comb begin
      res.out_blue  = pix.dst_blue;
      res.out_green = pix.dst_green;
      res.out_red   = pix.dst_red;
      res.dst_kept  = 1'b0;
      case (cfg.blend_mode)
         MODE_COPY: begin
            res.out_blue  = pix.src_blue;
            res.out_green = pix.src_green;
            res.out_red   = pix.src_red;
         end
         MODE_BLEND: begin
            res.out_blue  = mix_blue;
            res.out_green = mix_green;
            res.out_red   = mix_red;
         end
         MODE_KEY: begin
            if (key_hit) begin
               res.dst_kept = 1'b1;
            end else begin
               res.out_blue  = pix.src_blue;
               res.out_green = pix.src_green;
               res.out_red   = pix.src_red;
            end
         end
         default: begin
            res.dst_kept = 1'b0;
         end
      endcase
   end

endmodule

FILE: verif/tb_pixel_composite_unit_core.sv
// Self-checking testbench for pixel_composite_unit_core: copy, alpha blend, color key
// and unused mode, with random idling, one long result stall and a field-by-field check.
// Depends on pcu_pkg and the pixel_composite_unit_core RTL.
module tb_pixel_composite_unit_core;
   import pcu_pkg::*;

   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
   localparam int unsigned STALL_LIMIT = 3000;
   localparam int unsigned LONG_HOLD = 120;
   localparam int unsigned HOLD_AFTER = 300;
   localparam int unsigned PHASE_ITEMS = 115;
   localparam int unsigned RANDOM_PHASES = 10;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   pcu_req_type            req_data = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   pcu_rsp_type            rsp_data;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CHAN_W-1:0]      csr_wdata = '0;

   pcu_cfg_type shadow_cfg = '0;
   pcu_req_type pixel_feed_q[$];
   pcu_rsp_type composed_q[$];
   bit          idle_on = 1'b0;
   int unsigned req_gap = 0;
   int unsigned rsp_wait = 0;
   int unsigned long_hold = 0;
   bit          hold_done = 1'b0;
   int unsigned results_seen = 0;
   int unsigned error_count = 0;
   int unsigned quiet_cycles = 0;

   pixel_composite_unit_core uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [CHAN_W-1:0] mix_byte(input logic [CHAN_W-1:0] s,
                                                  input logic [CHAN_W-1:0] d,
                                                  input logic [CHAN_W-1:0] a);
      int sum;
      sum = int'(a) * int'(s) + (255 - int'(a)) * int'(d);
      return CHAN_W'(sum / 255);
   endfunction

   function automatic pcu_rsp_type composite_pixel(input pcu_req_type px);
      pcu_rsp_type r;
      r.out_blue  = px.dst_blue;
      r.out_green = px.dst_green;
      r.out_red   = px.dst_red;
      r.dst_kept  = 1'b0;
      case (shadow_cfg.blend_mode)
         MODE_COPY: begin
            r.out_blue  = px.src_blue;
            r.out_green = px.src_green;
            r.out_red   = px.src_red;
         end
         MODE_BLEND: begin
            r.out_blue  = mix_byte(px.src_blue, px.dst_blue, px.src_alpha);
            r.out_green = mix_byte(px.src_green, px.dst_green, px.src_alpha);
            r.out_red   = mix_byte(px.src_red, px.dst_red, px.src_alpha);
         end
         MODE_KEY: begin
            if (px.src_blue == shadow_cfg.key_blue && px.src_green == shadow_cfg.key_green &&
                px.src_red == shadow_cfg.key_red) begin
               r.dst_kept = 1'b1;
            end else begin
               r.out_blue  = px.src_blue;
               r.out_green = px.src_green;
               r.out_red   = px.src_red;
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   function automatic pcu_req_type make_pixel(input logic [CHAN_W-1:0] sb, sg, sr, sa,
                                              input logic [CHAN_W-1:0] db, dg, dr);
      pcu_req_type p;
      p = '{sb, sg, sr, sa, db, dg, dr};
      return p;
   endfunction

   // Biased toward the key color and near misses so the key compare is exercised.
   function automatic pcu_req_type rand_pixel();
      pcu_req_type p;
      int unsigned pick;
      logic [CHAN_W-1:0] flip;
      p.src_blue  = CHAN_W'($urandom);
      p.src_green = CHAN_W'($urandom);
      p.src_red   = CHAN_W'($urandom);
      p.src_alpha = CHAN_W'($urandom);
      p.dst_blue  = CHAN_W'($urandom);
      p.dst_green = CHAN_W'($urandom);
      p.dst_red   = CHAN_W'($urandom);
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
         p.src_blue  = shadow_cfg.key_blue;
         p.src_green = shadow_cfg.key_green;
         p.src_red   = shadow_cfg.key_red;
      end
      if (pick >= 4 && pick < 6) begin
         flip = CHAN_W'($urandom_range(1, 255));
         case ($urandom_range(0, 2))
            0: p.src_blue = p.src_blue ^ flip;
            1: p.src_green = p.src_green ^ flip;
            default: p.src_red = p.src_red ^ flip;
         endcase
      end
      pick = $urandom_range(0, 7);
      if (pick == 0) p.src_alpha = 8'h00;
      else if (pick == 1) p.src_alpha = 8'hFF;
      return p;
   endfunction

   function automatic int unsigned draw_gap();
      if (!idle_on || $urandom_range(0, 1) == 0) return 0;
      return $urandom_range(0, 11);
   endfunction

   task automatic check_field(input string name, input logic [CHAN_W-1:0] want,
                              input logic [CHAN_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
         error_count++;
      end
   endtask

   // Leaves csr_valid high so back-to-back writes need no re-raise.
   task automatic csr_write(input logic [CSR_INDEX_W-1:0] idx, input logic [CHAN_W-1:0] val);
      csr_index <= idx;
      csr_wdata <= val;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_BLEND_MODE: shadow_cfg.blend_mode = val[MODE_W-1:0];
         CSR_KEY_BLUE:   shadow_cfg.key_blue = val;
         CSR_KEY_GREEN:  shadow_cfg.key_green = val;
         CSR_KEY_RED:    shadow_cfg.key_red = val;
         default: ;
      endcase
   endtask

   task automatic program_regs(input logic [MODE_W-1:0] mode,
                               input logic [CHAN_W-1:0] kb, kg, kr);
      csr_write(CSR_BLEND_MODE, {(CHAN_W-MODE_W)'($urandom_range(0, 63)), mode});
      csr_write(CSR_KEY_BLUE, kb);
      csr_write(CSR_KEY_GREEN, kg);
      csr_write(CSR_KEY_RED, kr);
      csr_valid <= 1'b0;
   endtask

   task automatic drain_pixels();
      while (pixel_feed_q.size() != 0 || req_valid || composed_q.size() != 0)
         @(posedge clock);
   endtask

   // Driver: one transaction at a time from the feed queue, random gap after each.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_gap <= 0;
      end else begin
         if (req_valid && req_ready) composed_q.push_back(composite_pixel(req_data));
         if (!req_valid || req_ready) begin
            if (req_gap != 0) begin
               req_valid <= 1'b0;
               req_gap <= req_gap - 1;
            end else if (pixel_feed_q.size() != 0) begin
               req_valid <= 1'b1;
               req_data <= pixel_feed_q.pop_front();
               req_gap <= draw_gap();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks each result transaction, random back-pressure plus one long hold.
   always @(posedge clock) begin : rsp_monitor
      int unsigned wait_n;
      pcu_rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_wait <= 0;
         long_hold <= 0;
      end else begin
         wait_n = rsp_wait;
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (composed_q.size() == 0) begin
               $display("%0t: unexpected result, expected none, got %h", $time, rsp_data);
               error_count++;
            end else begin
               want = composed_q.pop_front();
               check_field("out_blue", want.out_blue, rsp_data.out_blue);
               check_field("out_green", want.out_green, rsp_data.out_green);
               check_field("out_red", want.out_red, rsp_data.out_red);
               check_field("dst_kept", CHAN_W'(want.dst_kept), CHAN_W'(rsp_data.dst_kept));
            end
            wait_n = draw_gap();
         end
         if (!hold_done && results_seen >= HOLD_AFTER) begin
            hold_done <= 1'b1;
            long_hold <= LONG_HOLD;
            rsp_ready <= 1'b0;
            rsp_wait <= wait_n;
         end else if (long_hold != 0) begin
            long_hold <= long_hold - 1;
            rsp_ready <= 1'b0;
            rsp_wait <= wait_n;
         end else if (wait_n != 0) begin
            rsp_wait <= wait_n - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_wait <= 0;
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      logic [MODE_W-1:0] mode_plan [RANDOM_PHASES];
      logic [CHAN_W-1:0] kb, kg, kr;
      mode_plan = '{MODE_BLEND, MODE_KEY, MODE_COPY, MODE_KEY, MODE_BLEND,
                    MODE_UNUSED, MODE_KEY, MODE_BLEND, MODE_COPY, MODE_KEY};
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      program_regs(MODE_COPY, 8'h00, 8'h00, 8'h00);
      pixel_feed_q.push_back(make_pixel(8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF));
      pixel_feed_q.push_back(make_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00));
      pixel_feed_q.push_back(make_pixel(8'hA5, 8'h5A, 8'h3C, 8'h80, 8'hC3, 8'h96, 8'h69));
      drain_pixels();

      // alpha extremes and full-range channels
      program_regs(MODE_BLEND, 8'hFF, 8'hFF, 8'hFF);
      pixel_feed_q.push_back(make_pixel(8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00));
      pixel_feed_q.push_back(make_pixel(8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
      pixel_feed_q.push_back(make_pixel(8'hC8, 8'h11, 8'h5A, 8'hFF, 8'h03, 8'hFA, 8'h80));
      pixel_feed_q.push_back(make_pixel(8'hC8, 8'h11, 8'h5A, 8'h00, 8'h03, 8'hFA, 8'h80));
      pixel_feed_q.push_back(make_pixel(8'hFF, 8'h00, 8'h80, 8'h80, 8'h00, 8'hFF, 8'h40));
      pixel_feed_q.push_back(make_pixel(8'hFF, 8'hFF, 8'hFF, 8'h01, 8'hFF, 8'hFF, 8'hFF));
      drain_pixels();

      // key hit and a miss on each channel
      program_regs(MODE_KEY, 8'h0C, 8'h22, 8'h38);
      pixel_feed_q.push_back(make_pixel(8'h0C, 8'h22, 8'h38, 8'h77, 8'h90, 8'hA0, 8'hB0));
      pixel_feed_q.push_back(make_pixel(8'h0D, 8'h22, 8'h38, 8'h77, 8'h90, 8'hA0, 8'hB0));
      pixel_feed_q.push_back(make_pixel(8'h0C, 8'hA2, 8'h38, 8'h77, 8'h90, 8'hA0, 8'hB0));
      pixel_feed_q.push_back(make_pixel(8'h0C, 8'h22, 8'h39, 8'h77, 8'h90, 8'hA0, 8'hB0));
      drain_pixels();

      program_regs(MODE_KEY, 8'h00, 8'h00, 8'h00);
      pixel_feed_q.push_back(make_pixel(8'h00, 8'h00, 8'h00, 8'h5A, 8'hFF, 8'hFF, 8'hFF));
      drain_pixels();

      program_regs(MODE_KEY, 8'hFF, 8'hFF, 8'hFF);
      pixel_feed_q.push_back(make_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00));
      pixel_feed_q.push_back(make_pixel(8'hFF, 8'hFF, 8'hFE, 8'h00, 8'h00, 8'h00, 8'h00));
      drain_pixels();

      // unused mode: destination passes, never flagged as kept
      program_regs(MODE_UNUSED, 8'h55, 8'hAA, 8'h3C);
      pixel_feed_q.push_back(make_pixel(8'h55, 8'hAA, 8'h3C, 8'hFF, 8'h12, 8'h34, 8'h56));
      pixel_feed_q.push_back(make_pixel(8'hFF, 8'h00, 8'hFF, 8'h80, 8'hED, 8'hCB, 8'hA9));
      drain_pixels();

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         kb = CHAN_W'($urandom);
         kg = CHAN_W'($urandom);
         kr = CHAN_W'($urandom);
         if (p == 3) {kb, kg, kr} = '0;
         if (p == 6) {kb, kg, kr} = '1;
         program_regs(mode_plan[p], kb, kg, kr);
         idle_on = (p % 3 != 2);
         repeat (PHASE_ITEMS) pixel_feed_q.push_back(rand_pixel());
         drain_pixels();
      end

      repeat (4) @(posedge clock);
      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
